[rtl/mexp_pkg.sv]
// mexp_pkg: shared types and constants of the modular exponentiation unit
// state encoding, controller commands, datapath status, register indexes
// no dependencies
package mexp_pkg;

    // configuration register indexes
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;         // item accepted: load exponent copy and accumulator
        logic start_reduce; // start message mod modulus on multiplier a
        logic take_reduce;  // reduced message becomes the running square
        logic start_step;   // start acc*square and square*square
        logic take_step;    // store square product, and acc product if the bit is set; shift exponent copy
        logic write_out;    // copy accumulator to the result register
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic exp_zero;     // exponent register is zero
        logic mod_small;    // modulus register below two
        logic e_zero;       // no set exponent bits left
        logic mul_a_done;
        logic mul_b_done;
    } dp_status_t;

endpackage

[rtl/modular_exponentiation_unit.sv]
// modular_exponentiation_unit: top level, right-to-left square-and-multiply
// depends on mexp_pkg, mexp_ctrl, mexp_datapath (and through it mexp_modmul)
//
// channel   | handshake              | payload
// ----------+------------------------+------------------------------------
// input     | in_valid / in_ready    | message_value
// output    | out_valid / out_ready  | result_value
// config    | cfg_write              | cfg_index, cfg_data
//
// zero exponent or modulus below two: the item goes straight to the finish step
// otherwise the message is reduced, then one square-and-multiply step per exponent
// bit up to the highest set one, then the finish step, each multiply done by the
// bit-serial modular multipliers
// one item at a time, next item taken the cycle after the result is written;
// a full output register stalls the finish step
// reset loads exponent 1 and modulus 2 and empties the output register
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [OPERAND_WIDTH-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OPERAND_WIDTH-1:0] message_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OPERAND_WIDTH-1:0] result_value
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // controller
    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    mexp_datapath #(
        .WIDTH(OPERAND_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .message_value (message_value),
        .cmd           (cmd),
        .status        (status),
        .result_value  (result_value)
    );

endmodule

[rtl/mexp_modmul.sv]
// mexp_modmul: iterative interleaved modular multiplier, one bit of b per cycle
// product a*b mod m for a < m, any b; done is raised when the product is ready
// depends on nothing
module mexp_modmul #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] m_reg;

    logic [WIDTH:0]   dbl;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] sum_red;
    logic [WIDTH-1:0] acc_next;

    // doubling then conditional add, each followed by one conditional subtract
    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {1'b0, m_reg})
            dbl_red = WIDTH'(dbl - {1'b0, m_reg});
        else
            dbl_red = dbl[WIDTH-1:0];
        sum = {1'b0, dbl_red} + {1'b0, a_reg};
        if (sum >= {1'b0, m_reg})
            sum_red = WIDTH'(sum - {1'b0, m_reg});
        else
            sum_red = sum[WIDTH-1:0];
        acc_next = b_reg[WIDTH-1] ? sum_red : dbl_red;
    end

    // control: busy flag, bit counter, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and partial result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/mexp_datapath.sv]
// mexp_datapath: configuration registers, square/accumulator registers,
// two modular multipliers and the result register
// depends on mexp_pkg and mexp_modmul
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [WIDTH-1:0] cfg_data,
    input  logic [WIDTH-1:0] message_value,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output logic [WIDTH-1:0] result_value
);

    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] e_shift_reg;
    logic [WIDTH-1:0] sq_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] result_reg;

    logic             mul_a_start;
    logic [WIDTH-1:0] mul_a_a;
    logic [WIDTH-1:0] mul_a_b;
    logic             mul_a_done;
    logic [WIDTH-1:0] mul_a_p;
    logic             mul_b_done;
    logic [WIDTH-1:0] mul_b_p;

    logic             exp_zero;
    logic             mod_small;

    assign exp_zero  = (exp_reg == '0);
    assign mod_small = (mod_reg[WIDTH-1:1] == '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= WIDTH'(1);
            mod_reg <= WIDTH'(2);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_EXPONENT: exp_reg <= cfg_data;
                REG_MODULUS:  mod_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // multiplier a reduces the message first (1 * msg mod m), then does acc * square
    assign mul_a_start = cmd.start_reduce | cmd.start_step;
    assign mul_a_a     = cmd.start_reduce ? WIDTH'(1) : acc_reg;
    assign mul_a_b     = cmd.start_reduce ? message_value : sq_reg;

    mexp_modmul #(
        .WIDTH(WIDTH)
    ) u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_a_start),
        .a       (mul_a_a),
        .b       (mul_a_b),
        .m       (mod_reg),
        .done    (mul_a_done),
        .product (mul_a_p)
    );

    // multiplier b squares the running square
    mexp_modmul #(
        .WIDTH(WIDTH)
    ) u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start_step),
        .a       (sq_reg),
        .b       (sq_reg),
        .m       (mod_reg),
        .done    (mul_b_done),
        .product (mul_b_p)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_shift_reg <= exp_reg;
            // zero exponent gives one, tiny modulus with a nonzero exponent gives zero
            acc_reg     <= (mod_small && !exp_zero) ? '0 : WIDTH'(1);
        end
        else if (cmd.take_step)
        begin
            if (e_shift_reg[0])
                acc_reg <= mul_a_p;
            e_shift_reg <= {1'b0, e_shift_reg[WIDTH-1:1]};
        end

        if (cmd.take_reduce)
            sq_reg <= mul_a_p;
        else if (cmd.take_step)
            sq_reg <= mul_b_p;

        if (cmd.write_out)
            result_reg <= acc_reg;
    end

    assign status.exp_zero   = exp_zero;
    assign status.mod_small  = mod_small;
    assign status.e_zero     = (e_shift_reg == '0);
    assign status.mul_a_done = mul_a_done;
    assign status.mul_b_done = mul_b_done;

    assign result_value = result_reg;

endmodule

[rtl/mexp_ctrl.sv]
// mexp_ctrl: controller state machine of the modular exponentiation unit
// sequences reduction, square-and-multiply steps and the output register
// depends on mexp_pkg
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.exp_zero || status.mod_small)
                        state_next = ST_FINISH;
                    else
                    begin
                        cmd.start_reduce = 1'b1;
                        state_next       = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (status.mul_a_done)
                begin
                    cmd.take_reduce = 1'b1;
                    state_next      = ST_STEP;
                end
            end
            ST_STEP:
            begin
                // stop once no set exponent bits remain
                if (status.e_zero)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.start_step = 1'b1;
                    state_next     = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.mul_a_done && status.mul_b_done)
                begin
                    cmd.take_step = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register holds one item until taken
    always_comb
    begin
        if (cmd.write_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule
